// ----- src/token_reassembly_tracker_defines.svh -----
// ----------------------------------------------------------------------------
// token_reassembly_tracker_defines.svh
// Assertion macros used by the token reassembly tracker RTL.
// ----------------------------------------------------------------------------
`ifndef TOKEN_REASSEMBLY_TRACKER_DEFINES_SVH
`define TOKEN_REASSEMBLY_TRACKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TRT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TRT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/trt_pkg.sv -----
// ----------------------------------------------------------------------------
// trt_pkg
// Shared widths, codes and structs of the token reassembly tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package trt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int ID_W          = 16;
    localparam int LEN_W         = 8;
    localparam int TIME_W        = 32;
    localparam int COUNT_W       = 32;
    localparam int STATUS_W      = 3;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PEND_W        = 5;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_PARTIAL  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_COMPLETE = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_MISMATCH = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_ZERO_LEN = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd4;

    // entry update commands
    localparam int CMD_W = 2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INC    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd3;

    // search probe, handed from cell to cell
    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic             hit;
        logic [IDX_W-1:0] hit_idx;
        logic [LEN_W-1:0] hit_len;
        logic [LEN_W-1:0] hit_rcv;
        logic             free_found;
        logic [IDX_W-1:0] free_idx;
    } probe_t;

    // entry update, broadcast to all cells
    typedef struct packed {
        logic             en;
        logic [CMD_W-1:0] op;
        logic [IDX_W-1:0] idx;
        logic [ID_W-1:0]  id;
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] rcv;
    } cmd_t;

endpackage

`default_nettype wire

// ----- src/trt_cell.sv -----
// ----------------------------------------------------------------------------
// trt_cell
// One table entry plus one stage of the search chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module trt_cell (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [trt_pkg::IDX_W-1:0] cell_idx,
    input  wire trt_pkg::probe_t           probe_in,
    input  wire trt_pkg::cmd_t             cmd,
    output trt_pkg::probe_t                probe_out
);

    logic                      valid_reg;
    logic [trt_pkg::ID_W-1:0]  id_reg;
    logic [trt_pkg::LEN_W-1:0] len_reg;
    logic [trt_pkg::LEN_W-1:0] rcv_reg;
    trt_pkg::probe_t           probe_reg;
    trt_pkg::probe_t           probe_next;
    logic                      sel;

    assign sel = cmd.en && (cmd.idx == cell_idx);

    // first valid match wins; the first free entry is also remembered
    always_comb begin
        probe_next = probe_in;
        if (probe_in.valid) begin
            if (valid_reg) begin
                if (!probe_in.hit && (id_reg == probe_in.id)) begin
                    probe_next.hit     = 1'b1;
                    probe_next.hit_idx = cell_idx;
                    probe_next.hit_len = len_reg;
                    probe_next.hit_rcv = rcv_reg;
                end
            end else if (!probe_in.free_found) begin
                probe_next.free_found = 1'b1;
                probe_next.free_idx   = cell_idx;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_reg.valid <= 1'b0;
        end else begin
            probe_reg.valid <= probe_next.valid;
        end
        probe_reg.id         <= probe_next.id;
        probe_reg.hit        <= probe_next.hit;
        probe_reg.hit_idx    <= probe_next.hit_idx;
        probe_reg.hit_len    <= probe_next.hit_len;
        probe_reg.hit_rcv    <= probe_next.hit_rcv;
        probe_reg.free_found <= probe_next.free_found;
        probe_reg.free_idx   <= probe_next.free_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (sel) begin
            unique case (cmd.op)
                trt_pkg::CMD_FREE:   valid_reg <= 1'b0;
                trt_pkg::CMD_INSERT: valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (sel) begin
            unique case (cmd.op)
                trt_pkg::CMD_INC, trt_pkg::CMD_FREE: begin
                    rcv_reg <= cmd.rcv;
                end
                trt_pkg::CMD_INSERT: begin
                    id_reg  <= cmd.id;
                    len_reg <= cmd.len;
                    rcv_reg <= cmd.rcv;
                end
                default: ;
            endcase
        end
    end

    assign probe_out = probe_reg;

endmodule

`default_nettype wire

// ----- src/token_reassembly_tracker.sv -----
// ----------------------------------------------------------------------------
// token_reassembly_tracker
// Tracks in-flight tokens and reports one status transaction per packet.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one packet per transaction (token id, length, arrival time).
//   m_ channel: one result per packet (status, completion time, completed
//   token count, pending token count).
//   A packet enters a probe that walks the row of table cells, one cell per
//   cycle, collecting the first matching entry and the lowest free entry.
//   After the last cell the result is decided, the chosen entry is updated
//   and the result lands in the output register.
//   s_tready is high only in the idle state, between packets, so the next
//   packet is accepted only after the previous one has been decided.
//   A result waiting in the output register does not block the next input
//   transaction; its decision step waits until the output register is free.
//   Reset (aresetn low, synchronous) empties the table and clears both
//   counters. A stall on m_tready holds the result and holds the next
//   decision, which keeps s_tready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "token_reassembly_tracker_defines.svh"

module token_reassembly_tracker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] tok_id, [23:16] token_length, [55:24] arrival_time
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [2:0] status, [34:3] complete_time, [66:35] completed_count,
    // [71:67] pending_count
    output logic [71:0]      m_tdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;

    logic [1:0] state_reg, state_next;

    logic [trt_pkg::LEN_W-1:0]  len_reg;
    logic [trt_pkg::TIME_W-1:0] time_reg;
    trt_pkg::probe_t            head_reg;
    trt_pkg::probe_t            tail_reg;
    trt_pkg::probe_t            chain [0:trt_pkg::TABLE_ENTRIES];
    trt_pkg::cmd_t              cmd;

    logic [trt_pkg::COUNT_W-1:0]  completed_reg, completed_next;
    logic [trt_pkg::PEND_W-1:0]   pending_reg, pending_next;
    logic                         out_valid_reg;
    logic [trt_pkg::STATUS_W-1:0] out_status_reg, status;
    logic [trt_pkg::TIME_W-1:0]   out_time_reg, ctime;
    logic [trt_pkg::COUNT_W-1:0]  out_completed_reg;
    logic [trt_pkg::PEND_W-1:0]   out_pending_reg;

    logic                      s_accept;
    logic                      out_free;
    logic                      decide;
    logic [trt_pkg::LEN_W-1:0] rcv_inc;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign decide   = (state_reg == ST_DECIDE) && out_free;

    // probe injection and capture of the finished probe
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg.valid <= 1'b0;
        end else begin
            head_reg.valid <= s_accept;
        end
        if (s_accept) begin
            head_reg.id         <= s_tdata[15:0];
            head_reg.hit        <= 1'b0;
            head_reg.hit_idx    <= '0;
            head_reg.hit_len    <= '0;
            head_reg.hit_rcv    <= '0;
            head_reg.free_found <= 1'b0;
            head_reg.free_idx   <= '0;
            len_reg             <= s_tdata[23:16];
            time_reg            <= s_tdata[55:24];
        end
        if (chain[trt_pkg::TABLE_ENTRIES].valid) begin
            tail_reg <= chain[trt_pkg::TABLE_ENTRIES];
        end
    end

    assign chain[0] = head_reg;

    for (genvar k = 0; k < trt_pkg::TABLE_ENTRIES; k++) begin : g_cell
        trt_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (trt_pkg::IDX_W'(k)),
            .probe_in  (chain[k]),
            .cmd       (cmd),
            .probe_out (chain[k+1])
        );
    end

    // decision on the finished probe
    assign rcv_inc = tail_reg.hit_rcv + trt_pkg::LEN_W'(1);

    always_comb begin
        cmd            = '0;
        cmd.idx        = tail_reg.hit_idx;
        cmd.id         = tail_reg.id;
        cmd.len        = len_reg;
        cmd.rcv        = rcv_inc;
        cmd.op         = trt_pkg::CMD_NONE;
        status         = trt_pkg::STAT_PARTIAL;
        ctime          = '0;
        completed_next = completed_reg;
        pending_next   = pending_reg;
        if (len_reg == '0) begin
            status = trt_pkg::STAT_ZERO_LEN;
        end else if (tail_reg.hit) begin
            if (tail_reg.hit_len != len_reg) begin
                status = trt_pkg::STAT_MISMATCH;
            end else if (rcv_inc == len_reg) begin
                cmd.op         = trt_pkg::CMD_FREE;
                status         = trt_pkg::STAT_COMPLETE;
                ctime          = time_reg;
                completed_next = completed_reg + trt_pkg::COUNT_W'(1);
                pending_next   = pending_reg - trt_pkg::PEND_W'(1);
            end else begin
                cmd.op = trt_pkg::CMD_INC;
            end
        end else if (len_reg == trt_pkg::LEN_W'(1)) begin
            status         = trt_pkg::STAT_COMPLETE;
            ctime          = time_reg;
            completed_next = completed_reg + trt_pkg::COUNT_W'(1);
        end else if (!tail_reg.free_found) begin
            status = trt_pkg::STAT_FULL;
        end else begin
            cmd.op       = trt_pkg::CMD_INSERT;
            cmd.idx      = tail_reg.free_idx;
            cmd.rcv      = trt_pkg::LEN_W'(1);
            pending_next = pending_reg + trt_pkg::PEND_W'(1);
        end
        cmd.en = decide && (cmd.op != trt_pkg::CMD_NONE);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_accept) state_next = ST_SEARCH;
            ST_SEARCH: if (chain[trt_pkg::TABLE_ENTRIES].valid) state_next = ST_DECIDE;
            ST_DECIDE: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            completed_reg <= '0;
            pending_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (decide) begin
                completed_reg <= completed_next;
                pending_reg   <= pending_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result until the transaction completes
    always_ff @(posedge aclk) begin
        if (decide) begin
            out_status_reg    <= status;
            out_time_reg      <= ctime;
            out_completed_reg <= completed_next;
            out_pending_reg   <= pending_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pending_reg, out_completed_reg, out_time_reg, out_status_reg};

    `TRT_ASSERT_NOW(a_pending_bound, aclk, aresetn, 1'b1,
        pending_reg <= trt_pkg::PEND_W'(trt_pkg::TABLE_ENTRIES), "pending count overflow")
    `TRT_ASSERT_NEXT(a_accept_injects, aclk, aresetn, s_accept,
        head_reg.valid && (state_reg == ST_SEARCH), "accepted packet not injected")
    `TRT_ASSERT_NEXT(a_decide_output, aclk, aresetn, decide,
        out_valid_reg && (state_reg == ST_IDLE), "decision produced no result")
    `TRT_ASSERT_NOW(a_time_only_on_complete, aclk, aresetn,
        out_valid_reg && (out_status_reg != trt_pkg::STAT_COMPLETE),
        out_time_reg == '0, "completion time set on non-complete result")

endmodule

`default_nettype wire
